[rtl/deq_pkg.sv]
// shared types and constants for the double-ended queue
package deq_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COUNT_W = 5;
   localparam int WORD_W  = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2
   } status_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic   en;
      op_type op;
   } cell_ctrl_type;

endpackage

[rtl/deq_if.sv]
// request and response channel interfaces
interface deq_req_if;
   import deq_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   word_type   push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   word_type             popped_value;
   word_type             front_value;
   word_type             rear_value;
   logic                 queue_empty;
   logic [COUNT_W-1:0]   element_count;

   modport source (output valid, output status, output popped_value, output front_value,
                   output rear_value, output queue_empty, output element_count,
                   input ready);
   modport sink   (input valid, input status, input popped_value, input front_value,
                   input rear_value, input queue_empty, input element_count,
                   output ready);
endinterface

[rtl/double_ended_queue.sv]
// a taken request's result goes to the pending result register, then to the response register
// no new request is taken while the pending result register holds a result; that register sits
// between the cell row update and the response register
// reset: synchronous, empties every cell and the element count; no clearing pass
module double_ended_queue (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req,
   deq_rsp_if.source rsp
);
   import deq_pkg::*;

   cell_ctrl_type        ctrl;
   word_type             cell_data  [DEPTH];
   logic                 cell_valid [DEPTH];
   word_type             cell_rear  [DEPTH];
   word_type             rear_word;
   logic                 q_empty, q_full, accept, load;
   op_type               op;
   status_type           status_in;
   word_type             popped_in;

   logic                 pend_ff;
   status_type           pend_status_ff;
   word_type             pend_popped_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   word_type             rsp_popped_ff, rsp_front_ff, rsp_rear_ff;
   logic                 rsp_empty_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   assign op      = op_type'(req.req_type);
   assign q_empty = !cell_valid[0];
   assign q_full  = cell_valid[DEPTH-1];
   assign accept  = req.valid && req.ready;
   assign load    = pend_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !pend_ff;

   always_comb begin
      status_in = ST_DONE;
      popped_in = '0;
      count_in  = count_ff;
      ctrl.en   = 1'b0;
      ctrl.op   = op;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (q_full) begin
               status_in = ST_PUSH_FULL;
            end else begin
               ctrl.en  = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (q_empty) begin
               status_in = ST_POP_EMPTY;
            end else begin
               ctrl.en   = accept;
               count_in  = count_ff - 1'b1;
               popped_in = (op == OP_POP_FRONT) ? cell_data[0] : rear_word;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // only the last held cell drives its tap, so an or of the taps selects it
   always_comb begin
      rear_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_word = rear_word | cell_rear[i];
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type ld, rd;
      logic     lv, rv;
      if (i == 0) begin : g_first
         assign ld = req.push_value;
         assign lv = 1'b1;
      end else begin : g_mid
         assign ld = cell_data[i-1];
         assign lv = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rd = '0;
         assign rv = 1'b0;
      end else begin : g_body
         assign rd = cell_data[i+1];
         assign rv = cell_valid[i+1];
      end
      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_value  (req.push_value),
         .left_data   (ld),
         .left_valid  (lv),
         .right_data  (rd),
         .right_valid (rv),
         .data_out    (cell_data[i]),
         .valid_out   (cell_valid[i]),
         .rear_tap    (cell_rear[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_ff  <= 1'b1;
            count_ff <= count_in;
         end else if (load) begin
            pend_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         pend_status_ff <= status_in;
         pend_popped_ff <= popped_in;
      end
      // cell row already holds the post-request state here
      if (load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_popped_ff <= pend_popped_ff;
         rsp_front_ff  <= q_empty ? '0 : cell_data[0];
         rsp_rear_ff   <= rear_word;
         rsp_empty_ff  <= q_empty;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.popped_value  = rsp_popped_ff;
   assign rsp.front_value   = rsp_front_ff;
   assign rsp.rear_value    = rsp_rear_ff;
   assign rsp.queue_empty   = rsp_empty_ff;
   assign rsp.element_count = rsp_count_ff;

endmodule

[rtl/deq_cell.sv]
// one storage cell of the queue row, trading words with its neighbours
module deq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  deq_pkg::word_type      push_value,
   input  deq_pkg::word_type      left_data,
   input  logic                   left_valid,
   input  deq_pkg::word_type      right_data,
   input  logic                   right_valid,
   output deq_pkg::word_type      data_out,
   output logic                   valid_out,
   output deq_pkg::word_type      rear_tap
);
   import deq_pkg::*;

   word_type data_ff, data_in;
   logic     valid_ff, valid_in;
   logic     is_last;

   assign is_last = valid_ff && !right_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_PUSH_FRONT: begin
               data_in  = left_data;
               valid_in = left_valid;
            end
            OP_PUSH_REAR: begin
               // first empty cell after the held run takes the word
               if (!valid_ff && left_valid) begin
                  data_in  = push_value;
                  valid_in = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               data_in  = right_data;
               valid_in = right_valid;
            end
            OP_POP_REAR: begin
               if (is_last) valid_in = 1'b0;
            end
            default: begin
               data_in  = data_ff;
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign rear_tap  = is_last ? data_ff : '0;

endmodule
